/* hdl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared types and constants for the three-class task scheduler.
// ----------------------------------------------------------------------------
package tcs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_TASKS_DEF   = 256;

    localparam int ID_W    = 8;
    localparam int TIME_W  = 16;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam int          DIV10_SHIFT = 19;
    localparam logic [31:0] DIV10_MUL   = 32'd52429;

    localparam logic [BURST_W-1:0] RUN_MAX = '1;

    localparam logic MODE_ADD      = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef enum logic [1:0] {
        ST_QUEUED     = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        LVL_GOLD   = 2'd0,
        LVL_SILVER = 2'd1,
        LVL_BRONZE = 2'd2
    } t_level;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GOLD_LIMIT     = 3'd0,
        CFG_SILVER_LIMIT   = 3'd1,
        CFG_SILVER_BURST   = 3'd2,
        CFG_SILVER_QUANTUM = 3'd3,
        CFG_BRONZE_QUANTUM = 3'd4
    } t_cfg_idx;

    localparam logic [PRIO_W-1:0]  GOLD_LIMIT_RST     = 8'd20;
    localparam logic [PRIO_W-1:0]  SILVER_LIMIT_RST   = 8'd60;
    localparam logic [BURST_W-1:0] SILVER_BURST_RST   = 4'd3;
    localparam logic [TIME_W-1:0]  SILVER_QUANTUM_RST = 16'd50;
    localparam logic [TIME_W-1:0]  BRONZE_QUANTUM_RST = 16'd100;

    typedef struct packed {
        logic              mode;
        logic [PRIO_W-1:0] priority_value;
        logic [TIME_W-1:0] exec_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   task_id;
        logic [1:0]        level;
        logic [TIME_W-1:0] grant_time;
        logic [TIME_W-1:0] remaining_after;
        logic              finished;
        logic [TIME_W-1:0] full_time;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] total;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

/* hdl/tcs_queue.sv */
// ----------------------------------------------------------------------------
// tcs_queue
// Circular task FIFO. Head entry is visible combinationally; push and pop may
// happen in the same cycle (requeue of an unfinished task).
// ----------------------------------------------------------------------------
module tcs_queue
    import tcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_ctrl i_ctrl,
    input  t_entry  i_push_data,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry r_store [QUEUE_DEPTH];

    logic [PTR_W-1:0] r_head, r_tail, n_head, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head  = i_ctrl.pop  ? wrap_next(r_head) : r_head;
        n_tail  = i_ctrl.push ? wrap_next(r_tail) : r_tail;
        unique case ({i_ctrl.push, i_ctrl.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // write lands at the old tail; when full that is the slot being popped
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_store[r_tail] <= i_push_data;
        end
    end

    assign o_head       = r_store[r_head];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));

endmodule

/* hdl/three_class_task_scheduler.sv */
// ----------------------------------------------------------------------------
// three_class_task_scheduler
// Gold / silver / bronze task queues with add and dispatch requests.
// ----------------------------------------------------------------------------
// Pipeline: input beat to result beat passes through the input register and then
//   the result register; every item gives exactly one result beat.
// Throughput: one item per cycle while the output is not stalled; queue head read
//   and write-back are done between the two registers.
// Reset: synchronous, active low; clears queue pointers, counts, silver run
//   and task id, loads register defaults. Queue storage is not cleared.
module three_class_task_scheduler
    import tcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_TASKS   = MAX_TASKS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QUO_W = 32 - DIV10_SHIFT;

    // config
    logic [PRIO_W-1:0]  r_gold_limit, r_silver_limit;
    logic [BURST_W-1:0] r_silver_burst;
    logic [TIME_W-1:0]  r_silver_quantum, r_bronze_quantum;

    // pipeline
    logic      r_in_valid, r_out_valid;
    t_in_item  r_in;
    t_out_item r_out, n_out;
    logic      w_adv, w_fire;

    // scheduler state
    logic [BURST_W-1:0] r_run, n_run;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    logic [ID_W:0]      w_id_inc;

    t_q_ctrl w_ctrl [3];
    t_q_stat w_stat [3];
    t_entry  w_head [3];
    t_entry  w_push_data;

    logic [31:0]       w_prod;
    logic [QUO_W-1:0]  w_quo;
    logic [TIME_W-1:0] w_rounded;

    t_level            w_lvl;
    t_entry            w_sel;
    logic [TIME_W-1:0] w_cap, w_svc;
    logic              w_have;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;
    assign o_cfg_ready = 1'b1;

    // round down to a multiple of 10 ms
    assign w_prod    = 32'(r_in.exec_time) * DIV10_MUL;
    assign w_quo     = w_prod[31:DIV10_SHIFT];
    assign w_rounded = {w_quo, 3'b000} + {2'b00, w_quo, 1'b0};

    assign w_id_inc = {1'b0, r_next_id} + 1'b1;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_queue
            tcs_queue #(
                .QUEUE_DEPTH(QUEUE_DEPTH)
            ) u_queue (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl[g]),
                .i_push_data (w_push_data),
                .o_head      (w_head[g]),
                .o_stat      (w_stat[g])
            );
        end
    endgenerate

    always_comb begin
        n_run       = r_run;
        n_next_id   = r_next_id;
        n_out       = '0;
        w_push_data = '0;
        w_lvl       = LVL_GOLD;
        w_have      = 1'b1;
        w_sel       = w_head[LVL_GOLD];
        w_cap       = r_bronze_quantum;
        w_svc       = '0;
        for (int k = 0; k < 3; k++) begin
            w_ctrl[k] = '0;
        end

        if (r_in.mode == MODE_ADD) begin
            priority if (r_in.priority_value < r_gold_limit) begin
                w_lvl = LVL_GOLD;
            end else if (r_in.priority_value < r_silver_limit) begin
                w_lvl = LVL_SILVER;
            end else begin
                w_lvl = LVL_BRONZE;
            end
            n_next_id = (32'(w_id_inc) >= MAX_TASKS) ? '0 : w_id_inc[ID_W-1:0];
            w_push_data.id        = r_next_id;
            w_push_data.remaining = w_rounded;
            w_push_data.total     = w_rounded;
            n_out.task_id         = r_next_id;
            n_out.level           = w_lvl;
            n_out.remaining_after = w_rounded;
            n_out.full_time       = w_rounded;
            if (w_stat[w_lvl].full) begin
                n_out.status = ST_DROPPED;
            end else begin
                n_out.status = ST_QUEUED;
                w_ctrl[w_lvl].push = w_fire;
            end
        end else begin
            // silver yields to waiting bronze once the run hits the burst limit
            priority if (!w_stat[LVL_GOLD].empty) begin
                w_lvl = LVL_GOLD;
            end else if (!w_stat[LVL_SILVER].empty &&
                         (w_stat[LVL_BRONZE].empty || r_run < r_silver_burst)) begin
                w_lvl = LVL_SILVER;
                n_run = (r_run != RUN_MAX) ? r_run + 1'b1 : r_run;
            end else if (!w_stat[LVL_BRONZE].empty) begin
                w_lvl = LVL_BRONZE;
                n_run = '0;
            end else begin
                w_have = 1'b0;
            end

            w_sel = w_head[w_lvl];
            w_cap = (w_lvl == LVL_SILVER) ? r_silver_quantum : r_bronze_quantum;
            w_svc = (w_lvl != LVL_GOLD && w_sel.remaining > w_cap) ? w_cap
                                                                 : w_sel.remaining;
            w_push_data.id        = w_sel.id;
            w_push_data.remaining = w_sel.remaining - w_svc;
            w_push_data.total     = w_sel.total;

            if (w_have) begin
                w_ctrl[w_lvl].pop     = w_fire;
                n_out.status          = ST_DISPATCHED;
                n_out.task_id         = w_sel.id;
                n_out.level           = w_lvl;
                n_out.grant_time      = w_svc;
                n_out.full_time       = w_sel.total;
                if (w_sel.remaining > w_svc) begin
                    w_ctrl[w_lvl].push    = w_fire;
                    n_out.remaining_after = w_push_data.remaining;
                end else begin
                    n_out.finished = 1'b1;
                end
            end else begin
                n_out.status = ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run       <= '0;
            r_next_id   <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_run       <= n_run;
                r_next_id   <= n_next_id;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gold_limit     <= GOLD_LIMIT_RST;
            r_silver_limit   <= SILVER_LIMIT_RST;
            r_silver_burst   <= SILVER_BURST_RST;
            r_silver_quantum <= SILVER_QUANTUM_RST;
            r_bronze_quantum <= BRONZE_QUANTUM_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_GOLD_LIMIT:     r_gold_limit     <= i_cfg_data[PRIO_W-1:0];
                CFG_SILVER_LIMIT:   r_silver_limit   <= i_cfg_data[PRIO_W-1:0];
                CFG_SILVER_BURST:   r_silver_burst   <= i_cfg_data[BURST_W-1:0];
                CFG_SILVER_QUANTUM: r_silver_quantum <= i_cfg_data[TIME_W-1:0];
                CFG_BRONZE_QUANTUM: r_bronze_quantum <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
